[rtl/alk_pkg.sv]
// Package for the array list engine: field widths, request codes, FSM states
// and the per-cell command struct. No dependencies.
`timescale 1ns / 1ps

package alk_pkg;

  // Default parameter values of the top level.
  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed widths of the stream fields.
  localparam int OP_W    = 4;
  localparam int POS_W   = 6;
  localparam int VAL_W   = 32;
  localparam int CNT_O_W = 7;
  localparam int CAP_W   = 7;

  // Capacity after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Request codes.
  typedef enum logic [OP_W-1:0] {
    OP_INSERT_AT    = 4'd0,
    OP_REMOVE_AT    = 4'd1,
    OP_INSERT_FRONT = 4'd2,
    OP_INSERT_BACK  = 4'd3,
    OP_REMOVE_FRONT = 4'd4,
    OP_REMOVE_BACK  = 4'd5,
    OP_SEARCH       = 4'd6,
    OP_READ         = 4'd7,
    OP_REPLACE      = 4'd8
  } alk_op_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } alk_state_t;

  // Update command broadcast to every cell.
  typedef struct packed {
    logic ins;   // open a slot at the index and write the value there
    logic rem;   // close the slot at the index
    logic wr;    // overwrite the entry at the index
  } alk_cmd_t;

endpackage

[rtl/alk_cell.sv]
// One storage cell of the list chain: holds one entry, shifts with its
// neighbors on insert and remove, and compares its entry. Uses alk_pkg.
`timescale 1ns / 1ps

module alk_cell #(
  parameter int DATA_WIDTH = alk_pkg::DATA_WIDTH_DEF,
  parameter int IDX_W      = 8,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  alk_pkg::alk_cmd_t     cmd_i,
  input  logic [IDX_W-1:0]      idx_i,
  input  logic [IDX_W-1:0]      cnt_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  match_o,
  output logic [DATA_WIDTH-1:0] sel_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  // Next entry: take the left neighbor above an insert point, the right
  // neighbor from a removal point on, or the new value at the index.
  always_comb begin
    data_nxt = data_r;
    if (cmd_i.ins) begin
      if (MY_IDX > idx_i) begin
        data_nxt = left_i;
      end else if (MY_IDX == idx_i) begin
        data_nxt = value_i;
      end
    end else if (cmd_i.rem) begin
      if (MY_IDX >= idx_i) begin
        data_nxt = right_i;
      end
    end else if (cmd_i.wr && (MY_IDX == idx_i)) begin
      data_nxt = value_i;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // Compare limited to live entries, and read selection by index.
  assign match_o = (MY_IDX < cnt_i) && (data_r == value_i);
  assign sel_o   = (MY_IDX == idx_i) ? data_r : '0;
  assign data_o  = data_r;

endmodule

[rtl/array_list_engine_core.sv]
// Top level of the array list engine: request sequencer, count and capacity
// registers, result register and the chain of alk_cell. Uses alk_pkg.
`timescale 1ns / 1ps
//
// Usage:
//   Requests enter on the in_ stream (op, position, item_value in in_tdata).
//   Each request yields exactly one result on the out_ stream (ok,
//   found_index, read_value, entry_count, is_empty, is_full in out_tdata).
//   The capacity register is written through cfg_valid/cfg_ready/cfg_data;
//   cfg_ready is high outside reset, and writes belong to idle periods.
//   A request is latched, then all cells shift or compare in parallel, and
//   a resolve step picks the first match and loads the result register.
//   A new request is taken only once the last one has left that step.
//   The result register decouples the sides: a new request is taken while
//   a finished result still waits. If the receiver stalls, the next result
//   is held in the resolve step until the result register is free.
//   Reset clears the count, sets the capacity to 64 and drops out_tvalid;
//   in_tready and cfg_ready stay low while reset is held.
//   Entries are not cleared; no entry beyond the count is ever read.
//
module array_list_engine_core #(
  parameter int DEPTH      = alk_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = alk_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // op[3:0], position[9:4], item_value[41:10], zero pad
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // ok[0], found_index[7:1], read_value[39:8],
                                  // entry_count[46:40], is_empty[47], is_full[48], zero pad
  // Capacity write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [alk_pkg::CAP_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LW    = ((CNT_W > alk_pkg::CAP_W) ? CNT_W : alk_pkg::CAP_W) + 1;

  alk_pkg::alk_state_t state_r, state_nxt;

  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [alk_pkg::CAP_W-1:0]   cap_r;
  logic [alk_pkg::OP_W-1:0]    req_op_r;
  logic [alk_pkg::POS_W-1:0]   req_pos_r;
  logic [DATA_WIDTH-1:0]       req_val_r;
  logic [DEPTH-1:0]            match_r;
  logic [DATA_WIDTH-1:0]       rd_r;
  logic                        ok_r;
  logic                        is_search_r;

  logic                        out_valid_r, out_valid_nxt;
  logic                        out_ok_r;
  logic [alk_pkg::CNT_O_W-1:0] out_found_r;
  logic [alk_pkg::VAL_W-1:0]   out_rd_r;
  logic [alk_pkg::CNT_O_W-1:0] out_cnt_r;
  logic                        out_empty_r;
  logic                        out_full_r;

  logic in_accept;
  logic exec_en;
  logic done_load;

  alk_pkg::alk_cmd_t     cmd;
  logic [LW-1:0]         idx;
  logic [LW-1:0]         cnt_l;
  logic [LW-1:0]         cap_eff;
  logic                  ok_exec;
  logic                  rd_en;
  logic [DATA_WIDTH-1:0] rd_or;
  logic [LW-1:0]         found;
  logic                  hit;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] cell_sel  [DEPTH];
  logic [DEPTH-1:0]      cell_match;

  assign cfg_ready = rst_n;
  assign in_accept = in_tvalid && in_tready;
  assign cnt_l     = LW'(count_r);
  assign cap_eff   = (LW'(cap_r) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(cap_r);

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      alk_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = alk_pkg::ST_EXEC;
        end
      end
      alk_pkg::ST_EXEC: state_nxt = alk_pkg::ST_DONE;
      alk_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = alk_pkg::ST_IDLE;
        end
      end
      default: state_nxt = alk_pkg::ST_IDLE;
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    in_tready = 1'b0;
    exec_en   = 1'b0;
    done_load = 1'b0;
    case (state_r)
      alk_pkg::ST_IDLE: in_tready = rst_n;
      alk_pkg::ST_EXEC: exec_en   = 1'b1;
      alk_pkg::ST_DONE: done_load = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  // Request decode: target index, validity checks and the cell command.
  always_comb begin
    cmd     = '0;
    idx     = LW'(req_pos_r);
    ok_exec = 1'b0;
    rd_en   = 1'b0;
    case (req_op_r)
      alk_pkg::OP_INSERT_AT,
      alk_pkg::OP_INSERT_FRONT,
      alk_pkg::OP_INSERT_BACK: begin
        if (req_op_r == alk_pkg::OP_INSERT_FRONT) begin
          idx = '0;
        end else if (req_op_r == alk_pkg::OP_INSERT_BACK) begin
          idx = cnt_l;
        end
        ok_exec = (cnt_l < cap_eff) && (idx <= cnt_l);
        cmd.ins = ok_exec;
      end
      alk_pkg::OP_REMOVE_AT,
      alk_pkg::OP_REMOVE_FRONT,
      alk_pkg::OP_REMOVE_BACK: begin
        if (req_op_r == alk_pkg::OP_REMOVE_FRONT) begin
          idx = '0;
        end else if (req_op_r == alk_pkg::OP_REMOVE_BACK) begin
          idx = cnt_l - LW'(1);
        end
        ok_exec = (cnt_l != '0) && (idx < cnt_l);
        cmd.rem = ok_exec;
      end
      alk_pkg::OP_READ: begin
        ok_exec = idx < cnt_l;
        rd_en   = ok_exec;
      end
      alk_pkg::OP_REPLACE: begin
        ok_exec = idx < cnt_l;
        cmd.wr  = ok_exec;
      end
      default: ;
    endcase
  end

  // Count after the request.
  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // Gather the entry addressed by a read.
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_or = rd_or | cell_sel[i];
    end
  end

  // First match of a search; the count when nothing matched.
  always_comb begin
    found = cnt_l;
    hit   = |match_r;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        found = LW'(i);
      end
    end
  end

  // The chain of cells.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;
    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[g+1];
    end
    alk_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (LW),
      .INDEX      (g)
    ) u_cell (
      .clk     (clk),
      .cmd_i   (exec_en ? cmd : alk_pkg::alk_cmd_t'('0)),
      .idx_i   (idx),
      .cnt_i   (cnt_l),
      .value_i (req_val_r),
      .left_i  (left_d),
      .right_i (right_d),
      .data_o  (cell_data[g]),
      .match_o (cell_match[g]),
      .sel_o   (cell_sel[g])
    );
  end

  // Result valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= alk_pkg::ST_IDLE;
      count_r     <= '0;
      cap_r       <= alk_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (exec_en) begin
        count_r <= count_nxt;
      end
    end
  end

  // Request, match and result registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_op_r  <= in_tdata[3:0];
      req_pos_r <= in_tdata[9:4];
      req_val_r <= DATA_WIDTH'(in_tdata[41:10]);
    end
    if (exec_en) begin
      match_r     <= cell_match;
      rd_r        <= rd_en ? rd_or : '0;
      ok_r        <= ok_exec;
      is_search_r <= (req_op_r == alk_pkg::OP_SEARCH);
    end
    if (done_load) begin
      out_ok_r    <= is_search_r ? hit : ok_r;
      out_found_r <= is_search_r ? alk_pkg::CNT_O_W'(found)
                                 : alk_pkg::CNT_O_W'(count_r);
      out_rd_r    <= alk_pkg::VAL_W'(rd_r);
      out_cnt_r   <= alk_pkg::CNT_O_W'(count_r);
      out_empty_r <= (count_r == '0);
      out_full_r  <= (cnt_l >= cap_eff);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_full_r, out_empty_r, out_cnt_r, out_rd_r,
                       out_found_r, out_ok_r};

  // The count never runs past the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    LW'(count_r) <= LW'(DEPTH))
    else $error("entry count beyond store depth");

  // A successful insert grows the count by exactly one.
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_en && cmd.ins) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not advance the count");

  // The count only moves in the execute step.
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !exec_en |=> (count_r == $past(count_r)))
    else $error("count changed outside the execute step");

  // A new result only follows the resolve step.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == alk_pkg::ST_DONE))
    else $error("result raised without a resolved request");

  // A search hit always reports an index inside the list.
  a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
    (done_load && is_search_r && hit) |-> (found < cnt_l))
    else $error("search index outside the list");

endmodule

[sim/array_list_engine_core_tb.sv]
// Self-checking testbench for array_list_engine_core: drives list requests on the
// in_ stream, predicts every result in a scoreboard class, and checks the out_ stream.
// Depends on alk_pkg and the array_list_engine_core RTL.
`timescale 1ns / 1ps

module array_list_engine_core_tb;

  localparam int DEPTH = alk_pkg::DEPTH_DEF;
  localparam logic [alk_pkg::OP_W-1:0] OP_CODE_MAX = 4'hF;
  localparam logic [alk_pkg::CAP_W-1:0] CAP_MAX = 7'h7F;
  localparam logic [alk_pkg::VAL_W-1:0] VAL_ONES = 32'hFFFF_FFFF;
  localparam int MAX_GAP = 40;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 8;

  // One predicted result, field by field.
  typedef struct {
    bit                      ok;
    bit [6:0]                found_index;
    bit [alk_pkg::VAL_W-1:0] read_value;
    bit [6:0]                entry_count;
    bit                      is_empty;
    bit                      is_full;
  } list_response_t;

  // Shadow copy of the list plus the queue of results still owed by the block.
  class list_scoreboard;
    bit [alk_pkg::VAL_W-1:0] entries [DEPTH];
    int unsigned    count;
    int unsigned    capacity;
    list_response_t expected_responses [$];
    int             errors;

    function new();
      count    = 0;
      capacity = alk_pkg::CAP_RESET;
      errors   = 0;
    endfunction

    // Capacities above the store depth are clipped to the depth.
    function int unsigned usable_capacity();
      return (capacity > DEPTH) ? DEPTH : capacity;
    endfunction

    function bit open_slot(int unsigned idx, bit [alk_pkg::VAL_W-1:0] v);
      if (count >= usable_capacity() || idx > count) return 1'b0;
      for (int unsigned i = count; i > idx; i--) entries[i] = entries[i-1];
      entries[idx] = v;
      count++;
      return 1'b1;
    endfunction

    function bit close_slot(int unsigned idx);
      if (count == 0 || idx >= count) return 1'b0;
      for (int unsigned i = idx; i + 1 < count; i++) entries[i] = entries[i+1];
      count--;
      return 1'b1;
    endfunction

    // Apply one request to the shadow list and return the result it must produce.
    function list_response_t predict_response(logic [alk_pkg::OP_W-1:0] op,
                                              logic [alk_pkg::POS_W-1:0] pos,
                                              logic [alk_pkg::VAL_W-1:0] val);
      list_response_t r;
      bit hit;
      r.ok         = 1'b0;
      r.read_value = '0;
      case (op)
        alk_pkg::OP_INSERT_AT:    r.ok = open_slot(pos, val);
        alk_pkg::OP_REMOVE_AT:    r.ok = close_slot(pos);
        alk_pkg::OP_INSERT_FRONT: r.ok = open_slot(0, val);
        alk_pkg::OP_INSERT_BACK:  r.ok = open_slot(count, val);
        alk_pkg::OP_REMOVE_FRONT: r.ok = close_slot(0);
        alk_pkg::OP_REMOVE_BACK:  r.ok = (count != 0) ? close_slot(count - 1) : 1'b0;
        alk_pkg::OP_READ: begin
          if (pos < count) begin
            r.read_value = entries[pos];
            r.ok = 1'b1;
          end
        end
        alk_pkg::OP_REPLACE: begin
          if (pos < count) begin
            entries[pos] = val;
            r.ok = 1'b1;
          end
        end
        default: ;
      endcase
      // Outside a search, and for a search with no match, the index carries the count.
      r.found_index = 7'(count);
      hit = 1'b0;
      if (op == alk_pkg::OP_SEARCH) begin
        for (int unsigned i = 0; i < count && !hit; i++) begin
          if (entries[i] == val) begin
            r.found_index = 7'(i);
            r.ok = 1'b1;
            hit = 1'b1;
          end
        end
      end
      r.entry_count = 7'(count);
      r.is_empty    = (count == 0);
      r.is_full     = (count >= usable_capacity());
      return r;
    endfunction

    function void note_request(logic [alk_pkg::OP_W-1:0] op, logic [alk_pkg::POS_W-1:0] pos,
                               logic [alk_pkg::VAL_W-1:0] val);
      expected_responses.push_back(predict_response(op, pos, val));
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [55:0] d);
      list_response_t e;
      if (expected_responses.size() == 0) begin
        $error("result arrived with no request outstanding: %h", d);
        errors++;
        return;
      end
      e = expected_responses.pop_front();
      compare_field("ok",          e.ok,          d[0]);
      compare_field("found_index", e.found_index, d[7:1]);
      compare_field("read_value",  e.read_value,  d[39:8]);
      compare_field("entry_count", e.entry_count, d[46:40]);
      compare_field("is_empty",    e.is_empty,    d[47]);
      compare_field("is_full",     e.is_full,     d[48]);
    endfunction

    function int pending();
      return expected_responses.size();
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_tvalid = 1'b0;
  logic                        in_tready;
  logic [47:0]                 in_tdata = '0;  // op[3:0], position[9:4], item_value[41:10]
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [55:0]                 out_tdata;      // ok[0], found_index[7:1], read_value[39:8],
                                               // entry_count[46:40], is_empty[47], is_full[48]
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [alk_pkg::CAP_W-1:0]   cfg_data = '0;

  list_scoreboard sb;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int stall_run = 0;
  int quiet_cycles = 0;

  array_list_engine_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side: check each accepted result, then pick the next ready at random.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (stall_run >= MAX_GAP || $urandom_range(99) >= receiver_stall_pct) begin
      out_tready <= 1'b1;
      stall_run  <= 0;
    end else begin
      out_tready <= 1'b0;
      stall_run  <= stall_run + 1;
    end
  end

  // Watchdog: end the run if no request, result or write moves for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("array_list_engine_core_tb: FAIL");
      $finish;
    end
  end

  // Present one request, with a random gap ahead of it, and hold it until taken.
  task automatic send_request(int unsigned op, int unsigned pos,
                              logic [alk_pkg::VAL_W-1:0] val);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, val, alk_pkg::POS_W'(pos), alk_pkg::OP_W'(op)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(alk_pkg::OP_W'(op), alk_pkg::POS_W'(pos), val);
  endtask

  // Let every owed result come back, then let the pipeline settle.
  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [alk_pkg::CAP_W-1:0] cap);
    in_tvalid <= 1'b0;
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.capacity = cap;
    repeat (2) @(posedge clk);
  endtask

  // Positions mostly land on or next to live entries, sometimes anywhere.
  function automatic logic [alk_pkg::POS_W-1:0] choose_position();
    int unsigned p;
    if ($urandom_range(99) < 20) return alk_pkg::POS_W'($urandom);
    p = $urandom_range(sb.count);
    return (p > DEPTH - 1) ? alk_pkg::POS_W'(DEPTH - 1) : alk_pkg::POS_W'(p);
  endfunction

  // Values often repeat live entries so that searches hit and duplicates occur.
  function automatic logic [alk_pkg::VAL_W-1:0] choose_value();
    int r;
    r = $urandom_range(99);
    if (r < 35 && sb.count > 0) return sb.entries[$urandom_range(sb.count - 1)];
    if (r < 45) return '0;
    if (r < 55) return VAL_ONES;
    return alk_pkg::VAL_W'($urandom);
  endfunction

  task automatic random_request(int ins_pct, int rem_pct);
    int r;
    logic [alk_pkg::OP_W-1:0] op;
    r = $urandom_range(99);
    if (r < 3) begin
      op = alk_pkg::OP_W'($urandom_range(alk_pkg::OP_REPLACE + 1, OP_CODE_MAX));
    end else if (r < 3 + ins_pct) begin
      case ($urandom_range(2))
        0:       op = alk_pkg::OP_INSERT_AT;
        1:       op = alk_pkg::OP_INSERT_FRONT;
        default: op = alk_pkg::OP_INSERT_BACK;
      endcase
    end else if (r < 3 + ins_pct + rem_pct) begin
      case ($urandom_range(2))
        0:       op = alk_pkg::OP_REMOVE_AT;
        1:       op = alk_pkg::OP_REMOVE_FRONT;
        default: op = alk_pkg::OP_REMOVE_BACK;
      endcase
    end else begin
      case ($urandom_range(2))
        0:       op = alk_pkg::OP_SEARCH;
        1:       op = alk_pkg::OP_READ;
        default: op = alk_pkg::OP_REPLACE;
      endcase
    end
    send_request(op, choose_position(), choose_value());
  endtask

  task automatic run_phase(logic [alk_pkg::CAP_W-1:0] cap, int n, int ins_pct, int rem_pct,
                           int s_pct, int r_pct);
    write_capacity(cap);
    sender_idle_pct    = s_pct;
    receiver_stall_pct = r_pct;
    repeat (n) random_request(ins_pct, rem_pct);
  endtask

  // Directed requests: empty list, index boundaries, duplicates and bad codes.
  task automatic directed_requests();
    send_request(alk_pkg::OP_REMOVE_FRONT, 0, 0);
    send_request(alk_pkg::OP_REMOVE_BACK, 0, 0);
    send_request(alk_pkg::OP_REMOVE_AT, 0, 0);
    send_request(alk_pkg::OP_READ, 0, 0);
    send_request(alk_pkg::OP_REPLACE, 0, VAL_ONES);
    send_request(alk_pkg::OP_SEARCH, 0, 0);
    send_request(alk_pkg::OP_INSERT_BACK, 0, 32'h0000_0000);
    send_request(alk_pkg::OP_INSERT_FRONT, 0, VAL_ONES);
    send_request(alk_pkg::OP_INSERT_AT, 1, 32'hA5A5_A5A5);
    send_request(alk_pkg::OP_INSERT_AT, 5, 32'h1234_5678);
    send_request(alk_pkg::OP_INSERT_AT, 3, 32'h5A5A_5A5A);
    send_request(alk_pkg::OP_INSERT_BACK, 0, 32'hA5A5_A5A5);
    send_request(alk_pkg::OP_SEARCH, 0, 32'hA5A5_A5A5);
    send_request(alk_pkg::OP_SEARCH, 0, 32'h0BAD_CAFE);
    send_request(alk_pkg::OP_READ, 0, 0);
    send_request(alk_pkg::OP_READ, 4, 0);
    send_request(alk_pkg::OP_READ, 63, 0);
    send_request(alk_pkg::OP_REPLACE, 2, 32'hDEAD_BEEF);
    send_request(alk_pkg::OP_REPLACE, 63, 32'h0000_0001);
    send_request(alk_pkg::OP_READ, 2, 0);
    send_request(alk_pkg::OP_REMOVE_AT, 1, 0);
    send_request(alk_pkg::OP_REMOVE_AT, 63, 0);
    send_request(alk_pkg::OP_REMOVE_BACK, 0, 0);
    send_request(alk_pkg::OP_REMOVE_FRONT, 0, 0);
    send_request(alk_pkg::OP_REPLACE + 1, 7, VAL_ONES);
    send_request(OP_CODE_MAX, 63, VAL_ONES);
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_requests();

    // Fill to the top of the store, then cycle through capacity settings,
    // including above the depth, below the current count, and zero.
    run_phase(alk_pkg::CAP_RESET, 200, 60, 12, 0, 0);
    run_phase(CAP_MAX, 130, 35, 30, 77, 0);
    run_phase(7'd5, 110, 10, 55, 0, 77);
    run_phase(7'd0, 30, 40, 30, 16, 16);
    run_phase(7'd1, 40, 40, 30, 77, 0);
    run_phase(7'd20, 80, 40, 30, 16, 16);
    run_phase(alk_pkg::CAP_RESET, 60, 45, 25, 0, 0);

    in_tvalid <= 1'b0;
    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("array_list_engine_core_tb: PASS");
    end else begin
      $display("array_list_engine_core_tb: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/alk_pkg.sv
rtl/alk_cell.sv
rtl/array_list_engine_core.sv
sim/array_list_engine_core_tb.sv
